// ===== rtl/core/i2c_master_write_engine_assert.svh =====
// assertion macros used by the checker file
`ifndef I2C_MASTER_WRITE_ENGINE_ASSERT_SVH
`define I2C_MASTER_WRITE_ENGINE_ASSERT_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define I2CMW_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define I2CMW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/i2cmw_pkg.sv =====
// shared types and constants of the i2c master write engine
package i2cmw_pkg;

	// command codes
	localparam logic [1:0] CMD_TICK  = 2'd0;
	localparam logic [1:0] CMD_BEGIN = 2'd1;
	localparam logic [1:0] CMD_WRITE = 2'd2;

	// line sequencer phase codes
	localparam int unsigned PHASE_W = 4;
	localparam logic [PHASE_W-1:0] PH_IDLE = 4'd0;
	localparam logic [PHASE_W-1:0] PH_ST1  = 4'd1;
	localparam logic [PHASE_W-1:0] PH_ST2  = 4'd2;
	localparam logic [PHASE_W-1:0] PH_BLO  = 4'd3;
	localparam logic [PHASE_W-1:0] PH_BHI  = 4'd4;
	localparam logic [PHASE_W-1:0] PH_ALO  = 4'd5;
	localparam logic [PHASE_W-1:0] PH_AHI  = 4'd6;
	localparam logic [PHASE_W-1:0] PH_SP1  = 4'd7;
	localparam logic [PHASE_W-1:0] PH_SP2  = 4'd8;
	localparam logic [PHASE_W-1:0] PH_SP3  = 4'd9;

	localparam logic [7:0] PHASE_TICKS_RST = 8'd5;
	localparam logic [3:0] BITS_PER_BYTE   = 4'd8;

	// buffer write request from the sequencer to the byte buffer
	typedef struct packed {
		logic       en;
		logic [2:0] idx;
		logic [7:0] data;
	} buf_wr_t;

endpackage

// ===== rtl/core/i2cmw_buf.sv =====
// data byte buffer with registered read port and write forwarding
module i2cmw_buf #(
	parameter int unsigned BUFFER_DEPTH = 8,
	parameter int unsigned PTR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
) (
	input  logic                 clk,
	input  i2cmw_pkg::buf_wr_t   wr,
	input  logic [PTR_W-1:0]     raddr,
	output logic [7:0]           rdata
);

	logic [7:0]       mem [BUFFER_DEPTH];
	logic [7:0]       rdata_q;
	logic             wr_hit;
	logic [PTR_W-1:0] waddr;

	assign waddr  = PTR_W'(wr.idx);
	// slots at or beyond the depth are never written
	assign wr_hit = wr.en && ({29'd0, wr.idx} < 32'(BUFFER_DEPTH));

	always_ff @(posedge clk) begin
		if (wr_hit) begin
			mem[waddr] <= wr.data;
		end
		if (wr_hit && (waddr == raddr)) begin
			rdata_q <= wr.data;
		end else begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/core/i2cmw_seq.sv =====
// input stage, line sequencer and result register
module i2cmw_seq #(
	parameter int unsigned BUFFER_DEPTH = 8,
	parameter int unsigned PTR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         command,
	input  logic [7:0]         value,
	input  logic [2:0]         buffer_index,
	input  logic [3:0]         byte_count,
	input  logic               sda_in,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               scl_out,
	output logic               sda_out,
	output logic               busy_res,
	output logic               nack,
	output logic               done_res,
	input  logic [7:0]         phase_ticks,
	output i2cmw_pkg::buf_wr_t buf_wr,
	output logic [PTR_W-1:0]   buf_raddr,
	input  logic [7:0]         buf_rdata
);

	// input stage
	logic       v_s1;
	logic [1:0] cmd_s1;
	logic [7:0] val_s1;
	logic [2:0] bidx_s1;
	logic [3:0] cnt_s1;
	logic       sda_s1;

	// sequencer state
	logic [i2cmw_pkg::PHASE_W-1:0] ph_q, ph_d;
	logic [7:0]       sh_q, sh_d;
	logic [3:0]       bc_q, bc_d;
	logic [3:0]       bl_q, bl_d;
	logic [PTR_W-1:0] rp_q, rp_d;
	logic [7:0]       tc_q, tc_d;
	logic             nk_q, nk_d;

	// result register
	logic out_v_q;
	logic scl_q, sda_q, busy_q, nack_q, done_q;

	logic             proc;
	logic             scl_c, sda_c, done_c, nack_new;
	logic [7:0]       limit;
	logic [8:0]       tc_inc;
	logic [3:0]       bc_inc;
	logic [3:0]       bl_sat;
	logic [PTR_W-1:0] rp_inc;

	assign proc     = v_s1 && (!out_v_q || out_ready);
	assign in_ready = !v_s1 || proc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			v_s1 <= 1'b1;
		end else if (proc) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1  <= command;
			val_s1  <= value;
			bidx_s1 <= buffer_index;
			cnt_s1  <= byte_count;
			sda_s1  <= sda_in;
		end
	end

	assign limit  = (phase_ticks == 8'd0) ? 8'd1 : phase_ticks;
	assign tc_inc = {1'b0, tc_q} + 9'd1;
	assign bc_inc = bc_q + 4'd1;
	assign bl_sat = ({28'd0, cnt_s1} > 32'(BUFFER_DEPTH)) ? 4'(BUFFER_DEPTH) : cnt_s1;
	assign rp_inc = (rp_q == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : rp_q + 1'b1;
	assign nack_new = nk_q | sda_s1;

	// lines of the phase in force before this item
	always_comb begin
		case (ph_q)
			i2cmw_pkg::PH_ST2: begin scl_c = 1'b1; sda_c = 1'b0;     end
			i2cmw_pkg::PH_BLO: begin scl_c = 1'b0; sda_c = sh_q[7]; end
			i2cmw_pkg::PH_BHI: begin scl_c = 1'b1; sda_c = sh_q[7]; end
			i2cmw_pkg::PH_ALO: begin scl_c = 1'b0; sda_c = 1'b1;     end
			i2cmw_pkg::PH_SP1: begin scl_c = 1'b0; sda_c = 1'b0;     end
			i2cmw_pkg::PH_SP2: begin scl_c = 1'b1; sda_c = 1'b0;     end
			default:           begin scl_c = 1'b1; sda_c = 1'b1;     end
		endcase
	end

	always_comb begin
		ph_d   = ph_q;
		sh_d   = sh_q;
		bc_d   = bc_q;
		bl_d   = bl_q;
		rp_d   = rp_q;
		tc_d   = tc_q;
		nk_d   = nk_q;
		done_c = 1'b0;
		case (cmd_s1)
			i2cmw_pkg::CMD_BEGIN: begin
				if (ph_q == i2cmw_pkg::PH_IDLE) begin
					nk_d = 1'b0;
					sh_d = val_s1;
					bc_d = 4'd0;
					bl_d = bl_sat;
					rp_d = '0;
					tc_d = 8'd0;
					ph_d = i2cmw_pkg::PH_ST1;
				end
			end
			i2cmw_pkg::CMD_TICK: begin
				if (ph_q != i2cmw_pkg::PH_IDLE) begin
					tc_d = tc_inc[7:0];
					if (tc_inc >= {1'b0, limit}) begin
						tc_d = 8'd0;
						case (ph_q)
							i2cmw_pkg::PH_ST1: ph_d = i2cmw_pkg::PH_ST2;
							i2cmw_pkg::PH_ST2: ph_d = i2cmw_pkg::PH_BLO;
							i2cmw_pkg::PH_BLO: ph_d = i2cmw_pkg::PH_BHI;
							i2cmw_pkg::PH_BHI: begin
								sh_d = {sh_q[6:0], 1'b0};
								bc_d = bc_inc;
								ph_d = (bc_inc >= i2cmw_pkg::BITS_PER_BYTE) ?
									i2cmw_pkg::PH_ALO : i2cmw_pkg::PH_BLO;
							end
							i2cmw_pkg::PH_ALO: ph_d = i2cmw_pkg::PH_AHI;
							i2cmw_pkg::PH_AHI: begin
								nk_d = nack_new;
								if (nack_new || (bl_q == 4'd0)) begin
									ph_d = i2cmw_pkg::PH_SP1;
								end else begin
									sh_d = buf_rdata;
									rp_d = rp_inc;
									bl_d = bl_q - 4'd1;
									bc_d = 4'd0;
									ph_d = i2cmw_pkg::PH_BLO;
								end
							end
							i2cmw_pkg::PH_SP1: ph_d = i2cmw_pkg::PH_SP2;
							i2cmw_pkg::PH_SP2: ph_d = i2cmw_pkg::PH_SP3;
							i2cmw_pkg::PH_SP3: begin
								ph_d   = i2cmw_pkg::PH_IDLE;
								done_c = 1'b1;
							end
							default: ph_d = i2cmw_pkg::PH_IDLE;
						endcase
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q <= i2cmw_pkg::PH_IDLE;
			sh_q <= 8'd0;
			bc_q <= 4'd0;
			bl_q <= 4'd0;
			rp_q <= '0;
			tc_q <= 8'd0;
			nk_q <= 1'b0;
		end else if (proc) begin
			ph_q <= ph_d;
			sh_q <= sh_d;
			bc_q <= bc_d;
			bl_q <= bl_d;
			rp_q <= rp_d;
			tc_q <= tc_d;
			nk_q <= nk_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (proc) begin
			out_v_q <= 1'b1;
		end else if (out_ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			scl_q  <= scl_c;
			sda_q  <= sda_c;
			busy_q <= (ph_d != i2cmw_pkg::PH_IDLE);
			nack_q <= nk_d;
			done_q <= done_c;
		end
	end

	assign buf_wr.en   = proc && (cmd_s1 == i2cmw_pkg::CMD_WRITE);
	assign buf_wr.idx  = bidx_s1;
	assign buf_wr.data = val_s1;
	assign buf_raddr   = rp_q;

	assign out_valid = out_v_q;
	assign scl_out   = scl_q;
	assign sda_out   = sda_q;
	assign busy_res  = busy_q;
	assign nack      = nack_q;
	assign done_res  = done_q;

endmodule

// ===== rtl/core/i2c_master_write_engine.sv =====
// top level of the bit-level i2c master write engine
//
// usage
// - config channel (cfg_valid/cfg_ready/cfg_data) sets phase_ticks, the number of
//   tick commands each scl/sda phase is held; cfg_ready is always high, write it
//   only while no transaction runs and all results have been taken
// - input channel carries one command per transfer: tick, begin (address byte
//   in value, data byte count in byte_count), or buffer write (value at
//   buffer_index); load the buffer before begin
// - output channel returns one result per input transfer: the line levels of
//   the phase in force when the item arrived, busy, the sticky nack flag and
//   done on the tick that finishes the stop condition
// - the input register loads at the transfer and the result register loads when
//   the sequencer processes the item; one item per cycle is sustained while
//   out_ready stays high, limited by the single sequencer update per cycle
// - a stalled output holds its result and the input stage keeps one item,
//   so in_ready drops only when both are full and out_ready is low
// - reset leaves the sequencer idle with lines released, nack clear and
//   phase_ticks at 5; the buffer contents are not reset
// - a missing acknowledge sets nack and the sequencer goes straight to stop
module i2c_master_write_engine #(
	parameter int unsigned BUFFER_DEPTH = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	// input channel
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [1:0] command,
	input  logic [7:0] value,
	input  logic [2:0] buffer_index,
	input  logic [3:0] byte_count,
	input  logic       sda_in,
	// result channel
	output logic       out_valid,
	input  logic       out_ready,
	output logic       scl_out,
	output logic       sda_out,
	output logic       busy_res,
	output logic       nack,
	output logic       done_res,
	// configuration write channel
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [7:0] cfg_data
);

	localparam int unsigned PTR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;

	logic [7:0]         phase_ticks_q;
	i2cmw_pkg::buf_wr_t buf_wr;
	logic [PTR_W-1:0]   buf_raddr;
	logic [7:0]         buf_rdata;

	// configuration register, always ready for a transfer
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_ticks_q <= i2cmw_pkg::PHASE_TICKS_RST;
		end else if (cfg_valid && cfg_ready) begin
			phase_ticks_q <= cfg_data;
		end
	end

	// sequencer with its input and result registers
	i2cmw_seq #(
		.BUFFER_DEPTH (BUFFER_DEPTH),
		.PTR_W        (PTR_W)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.value        (value),
		.buffer_index (buffer_index),
		.byte_count   (byte_count),
		.sda_in       (sda_in),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.scl_out      (scl_out),
		.sda_out      (sda_out),
		.busy_res     (busy_res),
		.nack         (nack),
		.done_res     (done_res),
		.phase_ticks  (phase_ticks_q),
		.buf_wr       (buf_wr),
		.buf_raddr    (buf_raddr),
		.buf_rdata    (buf_rdata)
	);

	// data byte buffer, read address follows the sequencer read pointer
	i2cmw_buf #(
		.BUFFER_DEPTH (BUFFER_DEPTH),
		.PTR_W        (PTR_W)
	) u_buf (
		.clk   (clk),
		.wr    (buf_wr),
		.raddr (buf_raddr),
		.rdata (buf_rdata)
	);

endmodule

// ===== rtl/core/i2cmw_checker.sv =====
// port-level checker for the i2c master write engine and its bind
`include "i2c_master_write_engine_assert.svh"

module i2cmw_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic scl_out,
	input logic sda_out,
	input logic busy_res,
	input logic nack,
	input logic done_res
);

	logic [4:0] res;

	assign res = {scl_out, sda_out, busy_res, nack, done_res};

	// a finished stop leaves the sequencer idle
	`I2CMW_ASSERT_NOW(a_done_idle, out_valid && done_res, !busy_res, "done while busy")

	// an idle result always shows both lines released
	`I2CMW_ASSERT_NOW(a_idle_released, out_valid && !busy_res, scl_out && sda_out, "idle lines")

	// an empty result register never blocks the input side
	`I2CMW_ASSERT_NOW(a_ready_when_empty, !out_valid, in_ready, "input stalled when empty")

	// a stalled result holds
	`I2CMW_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(res), "result moved")

endmodule

bind i2c_master_write_engine i2cmw_checker u_chk (.*);

// ===== verif/i2cmw_tb_pkg.sv =====
// line sequencer predictor and result scoreboard for the i2c master write engine testbench
package i2cmw_tb_pkg;
	import i2cmw_pkg::*;

	localparam int unsigned BUF_SLOTS = 8;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct packed {
		logic scl;
		logic sda;
		logic busy;
		logic nack;
		logic done;
	} line_res_t;

	class line_scoreboard;
		logic [7:0] hold_ticks;
		logic [7:0] slot [BUF_SLOTS];
		logic [PHASE_W-1:0] ph;
		logic [7:0] shifter;
		logic [3:0] bits_sent;
		logic [3:0] bytes_left;
		logic [2:0] rptr;
		logic [7:0] tick_cnt;
		logic nack_seen;
		line_res_t expected_q[$];
		string field_tag[5];
		int unsigned errors;
		int unsigned results_seen;

		function new();
			hold_ticks = PHASE_TICKS_RST;
			ph = PH_IDLE;
			shifter = '0;
			bits_sent = '0;
			bytes_left = '0;
			rptr = '0;
			tick_cnt = '0;
			nack_seen = 1'b0;
			errors = 0;
			results_seen = 0;
			// indexed by bit position of line_res_t
			field_tag = '{"done_res", "nack", "busy_res", "sda_out", "scl_out"};
		endfunction

		function void set_hold(logic [7:0] v);
			hold_ticks = v;
		endfunction

		function bit idle();
			return ph == PH_IDLE;
		endfunction

		function bit at_ack();
			return ph == PH_AHI;
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction

		// {scl, sda} of the phase in force
		function logic [1:0] lines();
			case (ph)
				PH_ST2: return 2'b10;
				PH_BLO: return {1'b0, shifter[7]};
				PH_BHI: return {1'b1, shifter[7]};
				PH_ALO: return 2'b01;
				PH_SP1: return 2'b00;
				PH_SP2: return 2'b10;
				default: return 2'b11;
			endcase
		endfunction

		function void note_input(logic [1:0] cmd, logic [7:0] val, logic [2:0] idx,
				logic [3:0] cnt, logic sda_in);
			line_res_t r;
			logic [7:0] limit;
			r = '0;
			{r.scl, r.sda} = lines();
			case (cmd)
				CMD_BEGIN: begin
					if (ph == PH_IDLE) begin
						nack_seen = 1'b0;
						shifter = val;
						bits_sent = '0;
						bytes_left = (cnt > BUF_SLOTS) ? 4'(BUF_SLOTS) : cnt;
						rptr = '0;
						tick_cnt = '0;
						ph = PH_ST1;
						{r.scl, r.sda} = lines();
					end
				end
				CMD_WRITE: begin
					if (idx < BUF_SLOTS)
						slot[idx] = val;
				end
				CMD_TICK: begin
					if (ph != PH_IDLE) begin
						limit = (hold_ticks == 8'd0) ? 8'd1 : hold_ticks;
						tick_cnt = tick_cnt + 8'd1;
						if (tick_cnt >= limit) begin
							tick_cnt = '0;
							case (ph)
								PH_ST1: ph = PH_ST2;
								PH_ST2: ph = PH_BLO;
								PH_BLO: ph = PH_BHI;
								PH_BHI: begin
									shifter = shifter << 1;
									bits_sent = bits_sent + 4'd1;
									ph = (bits_sent >= BITS_PER_BYTE) ? PH_ALO : PH_BLO;
								end
								PH_ALO: ph = PH_AHI;
								PH_AHI: begin
									if (sda_in)
										nack_seen = 1'b1;
									if (nack_seen || bytes_left == 4'd0) begin
										ph = PH_SP1;
									end else begin
										shifter = slot[rptr % BUF_SLOTS];
										rptr = 3'((rptr + 1) % BUF_SLOTS);
										bytes_left = bytes_left - 4'd1;
										bits_sent = '0;
										ph = PH_BLO;
									end
								end
								PH_SP1: ph = PH_SP2;
								PH_SP2: ph = PH_SP3;
								PH_SP3: begin
									ph = PH_IDLE;
									r.done = 1'b1;
								end
								default: ph = PH_IDLE;
							endcase
						end
					end
				end
				default: ;
			endcase
			r.busy = (ph != PH_IDLE);
			r.nack = nack_seen;
			expected_q.push_back(r);
		endfunction

		task report(string msg);
			errors++;
			if (errors <= 40)
				$display("mismatch: %s", msg);
		endtask

		task check_result(line_res_t got);
			line_res_t want;
			results_seen++;
			if (expected_q.size() == 0) begin
				report($sformatf("result %0d arrived with nothing expected", results_seen));
			end else begin
				want = expected_q.pop_front();
				for (int b = 4; b >= 0; b--) begin
					if (got[b] !== want[b])
						report($sformatf("result %0d %s got %b want %b",
							results_seen, field_tag[b], got[b], want[b]));
				end
			end
		endtask
	endclass

endpackage

// ===== verif/tb_i2c_master_write_engine.sv =====
// top-level testbench of the i2c master write engine: directed and random transactions
module tb_i2c_master_write_engine;
	timeunit 1ns;
	timeprecision 1ps;

	import i2cmw_pkg::*;
	import i2cmw_tb_pkg::*;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] command;
	logic [7:0] value;
	logic [2:0] buffer_index;
	logic [3:0] byte_count;
	logic       sda_in;
	logic       out_valid;
	logic       out_ready;
	logic       scl_out;
	logic       sda_out;
	logic       busy_res;
	logic       nack;
	logic       done_res;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [7:0] cfg_data;

	// quiet stretches with no idling on either side
	logic calm;
	line_scoreboard sb;
	int unsigned items_sent;

	i2c_master_write_engine #(
		.BUFFER_DEPTH(BUF_SLOTS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.command(command),
		.value(value),
		.buffer_index(buffer_index),
		.byte_count(byte_count),
		.sda_in(sda_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.scl_out(scl_out),
		.sda_out(sda_out),
		.busy_res(busy_res),
		.nack(nack),
		.done_res(done_res),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// alternate between random idling and a stretch with none at all
	initial begin
		forever begin
			calm <= 1'b0;
			repeat ($urandom_range(300, 150)) @(posedge clk);
			calm <= 1'b1;
			repeat ($urandom_range(200, 100)) @(posedge clk);
		end
	end

	function automatic bit gap_now();
		return !calm && ($urandom_range(99) < 15);
	endfunction

	// one input transfer; valid stays up afterwards so back-to-back items need no re-raise
	task automatic send_item(logic [1:0] cmd, logic [7:0] val, logic [2:0] idx,
			logic [3:0] cnt, logic sda);
		while (gap_now()) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		value <= val;
		buffer_index <= idx;
		byte_count <= cnt;
		sda_in <= sda;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		// predictor advances in transfer order, so the next pick sees the current phase
		sb.note_input(cmd, val, idx, cnt, sda);
		items_sent++;
	endtask

	// tick with a data line level; at the acknowledge phase a high level means no ack
	task automatic send_tick(int unsigned nack_pct);
		logic lvl;
		lvl = sb.at_ack() ? ($urandom_range(99) < nack_pct) : 1'($urandom_range(1));
		send_item(CMD_TICK, 8'($urandom), 3'($urandom), 4'($urandom), lvl);
	endtask

	// step the sequencer back to idle, optionally mixing in writes and ignored commands
	task automatic run_to_idle(int unsigned nack_pct, bit noisy);
		int unsigned pick;
		while (!sb.idle()) begin
			pick = $urandom_range(99);
			if (!noisy || pick >= 12) begin
				send_tick(nack_pct);
			end else if (pick < 6) begin
				// buffer write during a transfer, may change a byte not yet loaded
				send_item(CMD_WRITE, 8'($urandom), 3'($urandom), 4'($urandom),
					1'($urandom));
			end else if (pick < 9) begin
				// begin while busy is dropped
				send_item(CMD_BEGIN, 8'($urandom), 3'($urandom), 4'($urandom),
					1'($urandom));
			end else begin
				send_item(CMD_UNUSED, 8'($urandom), 3'($urandom), 4'($urandom),
					1'($urandom));
			end
		end
	endtask

	// let every outstanding result come back, then the pipeline latency on top
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	// phase_ticks is only changed with the sequencer idle and nothing in flight
	task automatic write_hold(logic [7:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		sb.set_hold(v);
		@(posedge clk);
	endtask

	// mostly short byte counts, some long ones and some past the buffer depth
	function automatic logic [3:0] pick_count();
		int unsigned p;
		p = $urandom_range(99);
		if (p < 70)
			return 4'($urandom_range(3));
		if (p < 88)
			return 4'($urandom_range(8, 4));
		return 4'($urandom_range(15, 9));
	endfunction

	// one well-formed transaction with random content and some noise around it
	task automatic random_txn(bit shortest);
		repeat ($urandom_range(3)) begin
			send_item(CMD_WRITE, 8'($urandom), 3'($urandom), 4'($urandom), 1'($urandom));
		end
		if ($urandom_range(9) == 0)
			send_item(CMD_TICK, 8'($urandom), 3'($urandom), 4'($urandom), 1'($urandom));
		send_item(CMD_BEGIN, 8'($urandom), 3'($urandom),
			shortest ? 4'd0 : pick_count(), 1'($urandom));
		run_to_idle(8, 1'b1);
	endtask

	// result side: random back-pressure, every transfer checked in order
	initial begin
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				sb.check_result('{scl_out, sda_out, busy_res, nack, done_res});
			out_ready <= calm || ($urandom_range(99) >= 15);
		end
	end

	initial begin
		logic [7:0] hold_plan [6];
		logic [7:0] fill [BUF_SLOTS];
		int unsigned k;
		sb = new();
		items_sent = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		command <= CMD_TICK;
		value <= '0;
		buffer_index <= '0;
		byte_count <= '0;
		sda_in <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: tick while idle and an unknown command leave everything released
		send_item(CMD_TICK, 8'hff, 3'd7, 4'hf, 1'b1);
		send_item(CMD_UNUSED, 8'hff, 3'd7, 4'hf, 1'b1);
		// load every slot first so no transaction ever reads an unwritten one
		fill = '{8'h00, 8'hff, 8'h80, 8'h01, 8'ha5, 8'h5a, 8'h7f, 8'hfe};
		for (int i = 0; i < BUF_SLOTS; i++)
			send_item(CMD_WRITE, fill[i], 3'(i), 4'd0, 1'b0);

		// missing acknowledge on the address at the reset hold goes straight to stop
		send_item(CMD_BEGIN, 8'h00, 3'd0, 4'd2, 1'b0);
		run_to_idle(100, 1'b0);

		// begin clears nack, count past the depth saturates, all bytes acknowledged
		write_hold(8'd1);
		send_item(CMD_BEGIN, 8'hff, 3'd0, 4'hf, 1'b0);
		send_item(CMD_BEGIN, 8'h00, 3'd0, 4'd1, 1'b0);
		// last slot is not yet loaded, so the new byte goes out
		send_item(CMD_WRITE, 8'h3c, 3'd7, 4'd0, 1'b0);
		run_to_idle(0, 1'b0);

		// random: several hold settings including zero
		hold_plan = '{8'd2, 8'd0, 8'd3, 8'd1, 8'($urandom_range(6, 4)), 8'd1};
		k = 0;
		while (items_sent < 450) begin
			write_hold(hold_plan[k % 6]);
			// slower settings only get address-only transactions
			random_txn(hold_plan[k % 6] >= 8'd3);
			k++;
		end

		drain();
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("[i2c_master_write_engine] OK");
		end else begin
			$display("[i2c_master_write_engine] ERROR");
		end
		$finish;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("[i2c_master_write_engine] ERROR");
		$finish;
	end

endmodule

// ===== i2c_master_write_engine.f =====
+incdir+rtl/core
rtl/core/i2cmw_pkg.sv
rtl/core/i2cmw_buf.sv
rtl/core/i2cmw_seq.sv
rtl/core/i2c_master_write_engine.sv
rtl/core/i2cmw_checker.sv
verif/i2cmw_tb_pkg.sv
verif/tb_i2c_master_write_engine.sv
